[sv/prt_pkg.sv]
// Package with shared constants and types for the phase and rate tracker.
package prt_pkg;

    localparam int PHASE_FRAC_BITS = 6;
    localparam int SPEED_FRAC_BITS = 8;

    localparam int PH_FULL = 360 << PHASE_FRAC_BITS;
    localparam int PH_HALF = 180 << PHASE_FRAC_BITS;

    localparam int PHASE_W = 15;
    localparam int MAG_W   = 14;
    localparam int SPEED_W = 24;
    localparam int TIME_W  = 48;

    localparam int MS_PER_S     = 1000;
    localparam int DEG_PER_RPMS = 6;

    localparam int NUM_W = MAG_W + 10 + SPEED_FRAC_BITS;
    localparam int DEN_W = TIME_W + 3 + PHASE_FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W);

    localparam int SPD_MAX = 8388607;
    localparam int SPD_MIN = -8388608;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_ALPHA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_TMO    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_WEIGHT = 2'd3;

    localparam logic [8:0]  RST_PHASE_ALPHA  = 9'd64;
    localparam logic [13:0] RST_MIN_STEP     = 14'd64;
    localparam logic [15:0] RST_STALE_TMO    = 16'd2000;
    localparam logic [8:0]  RST_SPEED_WEIGHT = 9'd77;

    typedef enum logic [1:0] {
        EV_HELD    = 2'd0,
        EV_UPDATED = 2'd1,
        EV_STALE   = 2'd2,
        EV_SEEDED  = 2'd3
    } t_speed_event;

endpackage

[sv/phase_rate_tracker_top.sv]
// Top level of the rotor phase and speed tracker with its control sequencer.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_stall    | measured_phase, sample_time_ms
//  out     | output    | o_out_valid / i_out_stall  | phase, speed, valid flag, speed event
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | register index and write data
//
// A seeding sample goes from ST_DIFF to ST_DONE, a sample without a speed update
// runs on to ST_DECIDE, and a speed update waits in ST_DIV for the 32-step serial divider.
// The input stalls during reset and from the transfer until the result is loaded
// into the output register.
// A result waits in its register while the output stalls; reset is synchronous and
// clears the tracker state and loads the register defaults.
module phase_rate_tracker_top
    import prt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PHASE_W-1:0]   i_measured_phase,
    input  logic [TIME_W-1:0]    i_sample_time_ms,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [PHASE_W-1:0]   o_phase_estimate,
    output logic [SPEED_W-1:0]   o_speed_estimate,
    output logic                 o_estimate_valid,
    output logic [1:0]           o_speed_event,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_DECIDE,
        ST_DIV,
        ST_BLEND_MUL,
        ST_BLEND_ADD,
        ST_DONE
    } t_state;

    localparam logic signed [15:0] C_FULL16 = 16'(PH_FULL);
    localparam logic signed [15:0] C_HALF16 = 16'(PH_HALF);
    localparam logic signed [18:0] C_FULL19 = 19'(PH_FULL);
    localparam logic signed [27:0] C_MAX28  = 28'(SPD_MAX);
    localparam logic signed [27:0] C_MIN28  = 28'(SPD_MIN);

    t_state              r_state;
    logic [8:0]          r_alpha;
    logic [13:0]         r_min_step;
    logic [15:0]         r_timeout;
    logic [8:0]          r_weight;

    logic [PHASE_W-1:0]  r_phase;
    logic signed [SPEED_W-1:0] r_speed;
    logic                r_seeded;
    logic [TIME_W-1:0]   r_last_time;

    logic [PHASE_W-1:0]  r_meas_in;
    logic [TIME_W-1:0]   r_time_in;
    logic signed [15:0]  r_d;
    logic [TIME_W-1:0]   r_dt;
    logic signed [25:0]  r_pprod;
    logic [NUM_W-1:0]    r_num;
    logic [DEN_W-1:0]    r_den;
    logic                r_upd;
    logic                r_stale;
    logic signed [SPEED_W-1:0] r_rpm;
    logic signed [34:0]  r_bprod;
    t_speed_event        r_event;

    logic                r_out_valid;
    logic [PHASE_W-1:0]  r_out_phase;
    logic [SPEED_W-1:0]  r_out_speed;
    logic                r_out_seeded;
    t_speed_event        r_out_event;

    logic [PHASE_W-1:0]  w_meas;
    logic signed [15:0]  w_diff;
    logic signed [15:0]  w_dwrap;
    logic signed [15:0]  w_d;
    logic [MAG_W-1:0]    w_mag;
    logic signed [17:0]  w_pstep;
    logic signed [18:0]  w_psum;
    logic [PHASE_W-1:0]  w_pnext;
    logic                w_div_start;
    logic                w_div_done;
    logic [NUM_W-1:0]    w_quo;
    logic signed [SPEED_W-1:0] w_rpm;
    logic signed [24:0]  w_bdiff;
    logic signed [26:0]  w_bstep;
    logic signed [27:0]  w_bsum;
    logic signed [SPEED_W-1:0] w_bsat;
    logic                w_out_free;

    always_comb begin
        w_meas  = (r_meas_in >= PHASE_W'(PH_FULL)) ? r_meas_in - PHASE_W'(PH_FULL) : r_meas_in;
        w_diff  = $signed({1'b0, w_meas}) - $signed({1'b0, r_phase});
        w_dwrap = w_diff[15] ? w_diff + C_FULL16 : w_diff;
        w_d     = (w_dwrap > C_HALF16) ? w_dwrap - C_FULL16 : w_dwrap;
        w_mag   = MAG_W'(r_d[15] ? -r_d : r_d);

        w_pstep = 18'((r_pprod + 26'sd128) >>> 8);
        w_psum  = 19'(w_pstep) + $signed({4'b0, r_phase});
        if (w_psum < 19'sd0) begin
            w_pnext = PHASE_W'(w_psum + C_FULL19);
        end else if (w_psum >= C_FULL19) begin
            w_pnext = PHASE_W'(w_psum - C_FULL19);
        end else begin
            w_pnext = PHASE_W'(w_psum);
        end

        if (r_d[15]) begin
            w_rpm = (w_quo > NUM_W'(SPD_MAX + 1)) ? SPEED_W'(SPD_MIN)
                                                   : -$signed(w_quo[SPEED_W-1:0]);
        end else begin
            w_rpm = (w_quo > NUM_W'(SPD_MAX)) ? SPEED_W'(SPD_MAX)
                                               : $signed(w_quo[SPEED_W-1:0]);
        end

        w_bdiff = 25'(r_rpm) - 25'(r_speed);
        w_bstep = 27'((r_bprod + 35'sd128) >>> 8);
        w_bsum  = 28'(w_bstep) + 28'(r_speed);
        if (w_bsum > C_MAX28) begin
            w_bsat = SPEED_W'(SPD_MAX);
        end else if (w_bsum < C_MIN28) begin
            w_bsat = SPEED_W'(SPD_MIN);
        end else begin
            w_bsat = SPEED_W'(w_bsum);
        end
    end

    assign w_div_start = (r_state == ST_DECIDE) && r_upd;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    prt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha    <= RST_PHASE_ALPHA;
            r_min_step <= RST_MIN_STEP;
            r_timeout  <= RST_STALE_TMO;
            r_weight   <= RST_SPEED_WEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PHASE_ALPHA:  r_alpha    <= i_cfg_data[8:0];
                CFG_MIN_STEP:     r_min_step <= i_cfg_data[13:0];
                CFG_STALE_TMO:    r_timeout  <= i_cfg_data;
                CFG_SPEED_WEIGHT: r_weight   <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_speed     <= '0;
            r_seeded    <= 1'b0;
            r_last_time <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_meas_in <= i_measured_phase;
                        r_time_in <= i_sample_time_ms;
                        r_state   <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    r_last_time <= r_time_in;
                    if (!r_seeded) begin
                        r_phase  <= w_meas;
                        r_speed  <= '0;
                        r_seeded <= 1'b1;
                        r_event  <= EV_SEEDED;
                        r_state  <= ST_DONE;
                    end else begin
                        r_d     <= w_d;
                        r_dt    <= (r_time_in > r_last_time) ? r_time_in - r_last_time : '0;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_pprod <= r_d * $signed({1'b0, r_alpha});
                    r_num   <= NUM_W'(NUM_W'(w_mag) * NUM_W'(MS_PER_S)) << SPEED_FRAC_BITS;
                    r_den   <= DEN_W'(DEN_W'(r_dt) * DEN_W'(DEG_PER_RPMS)) << PHASE_FRAC_BITS;
                    r_upd   <= (r_dt != '0) && (w_mag > r_min_step);
                    r_stale <= (r_dt > TIME_W'(r_timeout));
                    r_state <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    r_phase <= w_pnext;
                    if (r_upd) begin
                        r_state <= ST_DIV;
                    end else if (r_stale) begin
                        r_speed <= '0;
                        r_event <= EV_STALE;
                        r_state <= ST_DONE;
                    end else begin
                        r_event <= EV_HELD;
                        r_state <= ST_DONE;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_rpm   <= w_rpm;
                        r_event <= EV_UPDATED;
                        if (r_speed == '0) begin
                            r_speed <= w_rpm;
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_BLEND_MUL;
                        end
                    end
                end
                ST_BLEND_MUL: begin
                    r_bprod <= w_bdiff * $signed({1'b0, r_weight});
                    r_state <= ST_BLEND_ADD;
                end
                ST_BLEND_ADD: begin
                    r_speed <= w_bsat;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_phase  <= r_phase;
                        r_out_speed  <= r_speed;
                        r_out_seeded <= r_seeded;
                        r_out_event  <= r_event;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall       = !i_rst_n || (r_state != ST_IDLE);
    assign o_cfg_ready      = i_rst_n;
    assign o_out_valid      = r_out_valid;
    assign o_phase_estimate = r_out_phase;
    assign o_speed_estimate = r_out_speed;
    assign o_estimate_valid = r_out_seeded;
    assign o_speed_event    = r_out_event;

endmodule

[sv/prt_div.sv]
// Restoring serial divider, one quotient bit per cycle.
module prt_div
    import prt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;

    logic [DEN_W:0] w_shift;
    logic [DEN_W:0] w_diff;
    logic           w_ge;

    assign w_shift = {r_rem, r_quo[NUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(NUM_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_den;
                r_quo  <= i_num;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
